### rtl/lfsa_pkg.sv
// Shared types and constants for the lowest free server allocator.
// Used by lfsa_ctrl, lfsa_datapath and lowest_free_server_allocator_unit.
`timescale 1ns / 1ps

package lfsa_pkg;

  // Widths of the item fields and of the stored tables
  localparam int RoomW  = 5;
  localparam int StartW = 32;
  localparam int EndW   = 48;
  localparam int UseW   = 32;
  localparam int SrvW   = 4;

  // Built server count, and the server count after reset
  localparam int MaxServersDefault = 16;
  localparam logic [RoomW-1:0] RoomReset = RoomW'(16);

  // Input transaction payload
  typedef struct packed {
    logic              first;
    logic [StartW-1:0] start_time;
    logic [StartW-1:0] stop_time;
  } lfsa_in_t;

  // Output transaction payload
  typedef struct packed {
    logic [SrvW-1:0] server;
    logic [EndW-1:0] actual_start;
    logic [SrvW-1:0] busiest_server;
    logic            bad_input;
  } lfsa_out_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // latch the job, clear tables on first, restart scan
    logic step;    // read the next server entry
    logic commit;  // write back the chosen server and load the result
  } lfsa_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic scan_last;  // the current read address is the last server in use
    logic out_free;   // the result register can take a new transaction
  } lfsa_sts_t;

endpackage

### rtl/lfsa_ctrl.sv
// Controller state machine of the lowest free server allocator.
// Depends on lfsa_pkg for the command and status structs.
`timescale 1ns / 1ps

module lfsa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lfsa_pkg::lfsa_sts_t sts_i,
  output lfsa_pkg::lfsa_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_WAIT   = 4'b0100,
    S_COMMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Sequence one job: accept, scan the servers, drain the last read, commit
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  // An accepted transaction always starts a scan
  a_load_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == S_SCAN)
    else $error("accepted job did not start a scan");

  // A commit only happens when the result register has room
  a_commit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> sts_i.out_free)
    else $error("commit while result register is full");

  // The state register always holds exactly one state
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register is not one-hot");
`endif

endmodule

### rtl/lfsa_datapath.sv
// Datapath of the lowest free server allocator: server tables, scan trackers,
// write-back and result register. Depends on lfsa_pkg.
`timescale 1ns / 1ps

module lfsa_datapath #(
  parameter int MAX_SERVERS = lfsa_pkg::MaxServersDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lfsa_pkg::lfsa_in_t             in_data_i,
  input  logic                           cfg_valid_i,
  input  logic [lfsa_pkg::RoomW-1:0]     cfg_data_i,
  input  lfsa_pkg::lfsa_cmd_t            cmd_i,
  output lfsa_pkg::lfsa_sts_t            sts_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output lfsa_pkg::lfsa_out_t            out_data_o
);

  localparam int IdxW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int CmpW = (lfsa_pkg::RoomW > IdxW + 1) ? lfsa_pkg::RoomW : IdxW + 1;
  localparam int EndW = lfsa_pkg::EndW;
  localparam int UseW = lfsa_pkg::UseW;
  localparam int StW  = lfsa_pkg::StartW;
  localparam int SrvW = lfsa_pkg::SrvW;
  localparam logic [CmpW-1:0] MaxC = CmpW'(MAX_SERVERS);

  // Configuration and job registers
  logic [lfsa_pkg::RoomW-1:0] room_q;
  lfsa_pkg::lfsa_in_t         item_q;
  logic                       bad_q;
  logic [StW-1:0]             prev_q;

  // Server tables with per-entry valid bits
  logic [EndW-1:0]        end_mem  [MAX_SERVERS];
  logic [UseW-1:0]        uses_mem [MAX_SERVERS];
  logic [MAX_SERVERS-1:0] ok_q;

  // Scan address and registered read
  logic [IdxW-1:0] addr_q, last_idx, rd_idx_q;
  logic            rd_vld_q, rd_ok_q;
  logic [EndW-1:0] rd_end_q;
  logic [UseW-1:0] rd_uses_q;

  // Scan trackers: first free, earliest end, most used
  logic            found_q;
  logic [IdxW-1:0] fidx_q, midx_q, bidx_q;
  logic [UseW-1:0] fuse_q, muse_q, best_q;
  logic [EndW-1:0] min_q;

  logic [CmpW-1:0] room_ext;
  logic [EndW-1:0] rd_end, st_ext, act, fin;
  logic [UseW-1:0] rd_uses, puse, newuse;
  logic [IdxW-1:0] pick, busy;
  logic [EndW:0]   sum;
  logic [StW-1:0]  dur, prev_eff;
  logic [IdxW+SrvW-1:0] pick_ext, busy_ext;
  logic            out_valid_q;
  lfsa_pkg::lfsa_out_t out_q;

  // Clamp the server count to 1..MAX_SERVERS and form the last index
  always_comb begin
    room_ext = CmpW'(room_q);
    if (room_ext == '0) begin
      last_idx = '0;
    end else if (room_ext > MaxC) begin
      last_idx = IdxW'(MAX_SERVERS - 1);
    end else begin
      last_idx = IdxW'(room_ext - CmpW'(1));
    end
  end

  assign sts_o = '{scan_last: (addr_q == last_idx),
                   out_free:  (!out_valid_q || out_ready_i)};

  // Take the configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      room_q <= lfsa_pkg::RoomReset;
    end else if (cfg_valid_i) begin
      room_q <= cfg_data_i;
    end
  end

  // Latch the job and check its order and duration
  assign prev_eff = in_data_i.first ? '0 : prev_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
      bad_q  <= (in_data_i.stop_time <= in_data_i.start_time) ||
                (in_data_i.start_time < prev_eff);
    end
  end

  // Pick the server and form the write-back values
  assign st_ext = EndW'(item_q.start_time);
  assign pick   = found_q ? fidx_q : midx_q;
  assign act    = found_q ? st_ext : min_q;
  assign puse   = found_q ? fuse_q : muse_q;
  assign dur    = item_q.stop_time - item_q.start_time;
  assign sum    = {1'b0, act} + (EndW + 1)'(dur);
  assign fin    = sum[EndW] ? '1 : sum[EndW-1:0];
  assign newuse = (puse == '1) ? puse : puse + UseW'(1);

  // Fold the chosen server's new count into the busiest server
  always_comb begin
    busy = bidx_q;
    if (!bad_q) begin
      if ((newuse > best_q) || ((newuse == best_q) && (pick < bidx_q))) begin
        busy = pick;
      end
    end
  end

  assign pick_ext = {{SrvW{1'b0}}, pick};
  assign busy_ext = {{SrvW{1'b0}}, busy};

  // Hold the previous start and the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      ok_q   <= '0;
    end else if (cmd_i.load) begin
      if (in_data_i.first) begin
        prev_q <= '0;
        ok_q   <= '0;
      end
    end else if (cmd_i.commit && !bad_q) begin
      prev_q       <= item_q.start_time;
      ok_q[pick]   <= 1'b1;
    end
  end

  // Write back the chosen server and read the scan address
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && !bad_q) begin
      end_mem[pick]  <= fin;
      uses_mem[pick] <= newuse;
    end
    rd_end_q  <= end_mem[addr_q];
    rd_uses_q <= uses_mem[addr_q];
    rd_ok_q   <= ok_q[addr_q];
    rd_idx_q  <= addr_q;
  end

  // Advance the scan address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q   <= '0;
      rd_vld_q <= 1'b0;
      found_q  <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.step;
      if (cmd_i.load) begin
        addr_q  <= '0;
        found_q <= 1'b0;
      end else begin
        if (cmd_i.step) begin
          addr_q <= addr_q + IdxW'(1);
        end
        if (rd_vld_q && !found_q && (rd_end <= st_ext)) begin
          found_q <= 1'b1;
        end
      end
    end
  end

  // Entries not written since the last clear read as zero
  assign rd_end  = rd_ok_q ? rd_end_q  : '0;
  assign rd_uses = rd_ok_q ? rd_uses_q : '0;

  // Update the trackers as read data arrives
  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      if (!found_q && (rd_end <= st_ext)) begin
        fidx_q <= rd_idx_q;
        fuse_q <= rd_uses;
      end
      if ((rd_idx_q == '0) || (rd_end < min_q)) begin
        min_q  <= rd_end;
        midx_q <= rd_idx_q;
        muse_q <= rd_uses;
      end
      if ((rd_idx_q == '0) || (rd_uses > best_q)) begin
        best_q <= rd_uses;
        bidx_q <= rd_idx_q;
      end
    end
  end

  // Load and drain the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q.server         <= bad_q ? '0 : pick_ext[SrvW-1:0];
      out_q.actual_start   <= bad_q ? '0 : act;
      out_q.busiest_server <= busy_ext[SrvW-1:0];
      out_q.bad_input      <= bad_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // The scan never reads beyond the servers in use
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> addr_q <= last_idx)
    else $error("scan address beyond server count");

  // A commit always presents a result on the next cycle
  a_commit_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> out_valid_q)
    else $error("commit did not present a result");

  // A rejected job reports server zero at time zero
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.bad_input |-> (out_q.server == '0) && (out_q.actual_start == '0))
    else $error("rejected job carries a server or start time");
`endif

endmodule

### rtl/lowest_free_server_allocator_unit.sv
// Top level of the lowest free server allocator.
// Instantiates lfsa_ctrl and lfsa_datapath; depends on lfsa_pkg.
//
//   Channel  Dir  Handshake               Payload
//   in       in   in_valid_i/in_ready_o   lfsa_in_t  (first, start_time, stop_time)
//   out      out  out_valid_o/out_ready_i lfsa_out_t (server, actual_start, busiest, bad)
//   cfg      in   cfg_valid_i/cfg_ready_o room_count, 5 bits
//
// After acceptance a job passes through S_SCAN over the servers in use, S_WAIT
// and S_COMMIT, and its result is registered; the next job is taken after the
// commit. The scan reads one table entry per cycle via a single memory read port.
// Reset clears the table valid bits and sets room_count to 16. A stalled result
// holds in the output register; the next job is accepted meanwhile and waits at commit.
`timescale 1ns / 1ps

module lowest_free_server_allocator_unit #(
  parameter int MAX_SERVERS = lfsa_pkg::MaxServersDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  lfsa_pkg::lfsa_in_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output lfsa_pkg::lfsa_out_t        out_data_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [lfsa_pkg::RoomW-1:0] cfg_data_i
);

  lfsa_pkg::lfsa_cmd_t cmd;
  lfsa_pkg::lfsa_sts_t sts;

  // Configuration writes land at once
  assign cfg_ready_o = 1'b1;

  lfsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lfsa_datapath #(
    .MAX_SERVERS (MAX_SERVERS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
